>>> sv/sbca_pkg.sv
package sbca_pkg;

	localparam int PORTS_DEF  = 64;
	localparam int QUEUES_DEF = 8;
	localparam int KILO       = 1000;
	localparam int CNT_W      = 32;
	localparam int KB_W       = 23;
	localparam int THR_W      = 33;
	localparam int PROB_W     = 16;

	typedef enum logic [2:0] {
		REQ_CHECK   = 3'd0,
		REQ_IN_ADD  = 3'd1,
		REQ_IN_REM  = 3'd2,
		REQ_EG_ADD  = 3'd3,
		REQ_EG_REM  = 3'd4,
		REQ_CREDIT  = 3'd5,
		REQ_ECN     = 3'd6,
		REQ_UNUSED  = 3'd7
	} req_kind_t;

	typedef enum logic [1:0] {
		REG_TOTAL   = 2'd0,
		REG_ECN_MIN = 2'd1,
		REG_ECN_MAX = 2'd2,
		REG_ECN_PROB = 2'd3
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC,
		ST_ECN
	} state_t;

	typedef struct packed {
		logic clear_step;
		logic accept;
		logic exec;
		logic ecn_fin;
	} cmd_t;

	typedef struct packed {
		logic clear_done;
		logic div_busy;
		logic is_ecn;
	} status_t;

endpackage

>>> sv/switch_buffer_credit_ecn_accounting_unit.sv
// Channel  | Signals                                                  | Flow
// ---------+----------------------------------------------------------+---------------------
// request  | start, busy, req_type, port_number, queue_number,        | word taken when
//          | packet_bytes, random_value                               | start && !busy
// result   | done, admit_ok, ecn_mark, credit_limit,                  | word valid for the
//          | sent_bytes_total, used_buffer_total                      | one cycle done is high
// config   | cfg_valid, cfg_ready, cfg_index, cfg_data                | word taken on valid && ready
//
// A request word is read from the synchronous counter memory when it is accepted, and is
// then updated and written back. An ECN query adds a further state for the RED comparison
// products. After reset a clearing sweep over all PORTS*QUEUES entries zeroes the counter
// memory, and busy stays high during it. Writing the total buffer size (config index 0)
// starts a share computation (a multiplication by a constant reciprocal, then a shift), with
// busy high meanwhile. The result side cannot stall; each result word is a one-cycle strobe.
module switch_buffer_credit_ecn_accounting_unit #(
	parameter int PORTS  = sbca_pkg::PORTS_DEF,
	parameter int QUEUES = sbca_pkg::QUEUES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  req_type,
	input  logic [5:0]  port_number,
	input  logic [2:0]  queue_number,
	input  logic [15:0] packet_bytes,
	input  logic [15:0] random_value,
	output logic        done,
	output logic        admit_ok,
	output logic        ecn_mark,
	output logic [31:0] credit_limit,
	output logic [31:0] sent_bytes_total,
	output logic [31:0] used_buffer_total,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	sbca_pkg::cmd_t    cmd;
	sbca_pkg::status_t sts;

	// Configuration is always accepted; a write of the total buffer size simply restarts the share computation.
	assign cfg_ready = 1'b1;

	sbca_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.sts    (sts)
	);

	sbca_datapath #(.PORTS(PORTS), .QUEUES(QUEUES)) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.sts               (sts),
		.cfg_we            (cfg_valid && cfg_ready),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.req_type          (req_type),
		.port_number       (port_number),
		.queue_number      (queue_number),
		.packet_bytes      (packet_bytes),
		.random_value      (random_value),
		.done              (done),
		.admit_ok          (admit_ok),
		.ecn_mark          (ecn_mark),
		.credit_limit      (credit_limit),
		.sent_bytes_total  (sent_bytes_total),
		.used_buffer_total (used_buffer_total)
	);

endmodule

>>> sv/sbca_ram.sv
module sbca_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> sv/sbca_ctrl.sv
module sbca_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	output sbca_pkg::cmd_t       cmd,
	input  sbca_pkg::status_t    sts
);

	sbca_pkg::state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sbca_pkg::ST_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			sbca_pkg::ST_CLEAR: begin
				if (sts.clear_done) state_nxt = sbca_pkg::ST_IDLE;
			end
			sbca_pkg::ST_IDLE: begin
				if (start && !sts.div_busy) state_nxt = sbca_pkg::ST_EXEC;
			end
			sbca_pkg::ST_EXEC: begin
				state_nxt = sts.is_ecn ? sbca_pkg::ST_ECN : sbca_pkg::ST_IDLE;
			end
			sbca_pkg::ST_ECN: begin
				state_nxt = sbca_pkg::ST_IDLE;
			end
			default: state_nxt = sbca_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		unique case (state_q)
			sbca_pkg::ST_CLEAR: cmd.clear_step = 1'b1;
			sbca_pkg::ST_IDLE: begin
				busy       = sts.div_busy;
				cmd.accept = start && !sts.div_busy;
			end
			sbca_pkg::ST_EXEC: cmd.exec = 1'b1;
			sbca_pkg::ST_ECN:  cmd.ecn_fin = 1'b1;
			default: cmd = '0;
		endcase
	end

endmodule

>>> sv/sbca_datapath.sv
module sbca_datapath #(
	parameter int PORTS  = sbca_pkg::PORTS_DEF,
	parameter int QUEUES = sbca_pkg::QUEUES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  sbca_pkg::cmd_t       cmd,
	output sbca_pkg::status_t    sts,
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_index,
	input  logic [31:0]          cfg_data,
	input  logic [2:0]           req_type,
	input  logic [5:0]           port_number,
	input  logic [2:0]           queue_number,
	input  logic [15:0]          packet_bytes,
	input  logic [15:0]          random_value,
	output logic                 done,
	output logic                 admit_ok,
	output logic                 ecn_mark,
	output logic [31:0]          credit_limit,
	output logic [31:0]          sent_bytes_total,
	output logic [31:0]          used_buffer_total
);

	localparam int ENTRIES = PORTS * QUEUES;
	localparam int AW      = $clog2(ENTRIES > 1 ? ENTRIES : 2);
	localparam int CW      = sbca_pkg::CNT_W;
	localparam int TW      = sbca_pkg::THR_W;
	localparam int LW      = TW + 17;
	localparam int PW      = TW + sbca_pkg::PROB_W;
	localparam int SHR_L   = $clog2(ENTRIES);
	localparam int MW      = CW + 1;
	localparam int PRW     = CW + MW;
	localparam logic [MW-1:0] RECIP =
		MW'(((64'd1 << (CW + SHR_L)) / 64'(ENTRIES)) + 64'd1);

	// configuration
	logic [CW-1:0]              total_q;
	logic [sbca_pkg::KB_W-1:0]  min_kb_q, max_kb_q;
	logic [sbca_pkg::PROB_W-1:0] prob_q;
	logic [TW-1:0]              kmin_q, kmax_q;

	// share computation
	logic [CW-1:0]  share_q;
	logic [PRW-1:0] prod_q;
	logic           div_cnt_q;
	logic           div_busy_q;

	// latched item
	logic [AW-1:0]  idx, idx_q, clr_q;
	logic           in_range, in_range_q;
	sbca_pkg::req_kind_t kind_q;
	logic           qnz_q;
	logic [15:0]    size_q, rnd_q;
	logic [CW-1:0]  used_q;

	// memory
	logic               ram_we;
	logic [AW-1:0]      ram_waddr;
	logic [4*CW-1:0]    ram_wdata, ram_rdata;
	logic [CW-1:0]      ing, egr, rcv, snt;
	logic [CW-1:0]      ing_n, egr_n, rcv_n, snt_n, used_n, free_share;
	logic               wr_item;

	// ecn stage
	logic           gtmax_s1, gtmin_s1, qnz_s1;
	logic [LW-1:0]  lhs_s1;
	logic [PW-1:0]  rhs_s1;
	logic [CW-1:0]  sent_s1;
	logic [TW-1:0]  e_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q  <= '0;
			min_kb_q <= '0;
			max_kb_q <= '0;
			prob_q   <= '0;
		end else if (cfg_we) begin
			unique case (sbca_pkg::cfg_reg_t'(cfg_index))
				sbca_pkg::REG_TOTAL:    total_q  <= cfg_data;
				sbca_pkg::REG_ECN_MIN:  min_kb_q <= cfg_data[sbca_pkg::KB_W-1:0];
				sbca_pkg::REG_ECN_MAX:  max_kb_q <= cfg_data[sbca_pkg::KB_W-1:0];
				sbca_pkg::REG_ECN_PROB: prob_q   <= cfg_data[sbca_pkg::PROB_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		kmin_q <= TW'(min_kb_q) * TW'(sbca_pkg::KILO);
		kmax_q <= TW'(max_kb_q) * TW'(sbca_pkg::KILO);
	end

	// The share is the buffer size divided by the entry count, formed as a
	// multiplication by a rounded-up reciprocal and a shift. The reciprocal is
	// exact for every 32-bit buffer size. The product is registered first, then shifted.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_busy_q <= 1'b0;
			div_cnt_q  <= 1'b0;
			share_q    <= '0;
			prod_q     <= '0;
		end else if (cfg_we && sbca_pkg::cfg_reg_t'(cfg_index) == sbca_pkg::REG_TOTAL) begin
			div_busy_q <= 1'b1;
			div_cnt_q  <= 1'b0;
		end else if (div_busy_q) begin
			if (!div_cnt_q) begin
				prod_q    <= PRW'(total_q) * PRW'(RECIP);
				div_cnt_q <= 1'b1;
			end else begin
				share_q    <= CW'(prod_q >> (CW + SHR_L));
				div_busy_q <= 1'b0;
			end
		end
	end

	// Clearing sweep after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clear_step) begin
			clr_q <= clr_q + AW'(1);
		end
	end

	assign in_range = (int'(port_number) < PORTS) && (int'(queue_number) < QUEUES);
	assign idx      = AW'(32'(port_number) * QUEUES + 32'(queue_number));

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			idx_q  <= idx;
			kind_q <= sbca_pkg::req_kind_t'(req_type);
			qnz_q  <= (queue_number != 3'd0);
			size_q <= packet_bytes;
			rnd_q  <= random_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_range_q <= 1'b0;
			used_q     <= '0;
		end else begin
			if (cmd.accept) in_range_q <= in_range;
			if (cmd.exec) used_q <= used_n;
		end
	end

	assign {ing, egr, rcv, snt} = ram_rdata;
	assign free_share = share_q - ing;

	always_comb begin
		ing_n   = ing;
		egr_n   = egr;
		rcv_n   = rcv;
		snt_n   = snt;
		used_n  = used_q;
		wr_item = 1'b0;
		if (in_range_q) begin
			case (kind_q)
				sbca_pkg::REQ_IN_ADD: begin
					rcv_n   = rcv + CW'(size_q);
					ing_n   = ing + CW'(size_q);
					used_n  = used_q + CW'(size_q);
					wr_item = 1'b1;
				end
				sbca_pkg::REQ_IN_REM: begin
					ing_n   = (ing >= CW'(size_q)) ? ing - CW'(size_q) : '0;
					used_n  = (used_q >= CW'(size_q)) ? used_q - CW'(size_q) : '0;
					wr_item = 1'b1;
				end
				sbca_pkg::REQ_EG_ADD: begin
					egr_n   = egr + CW'(size_q);
					wr_item = 1'b1;
				end
				sbca_pkg::REQ_EG_REM: begin
					snt_n   = snt + CW'(size_q);
					egr_n   = (egr >= CW'(size_q)) ? egr - CW'(size_q) : '0;
					wr_item = 1'b1;
				end
				default: ;
			endcase
		end
	end

	assign ram_we    = cmd.clear_step || (cmd.exec && wr_item);
	assign ram_waddr = cmd.clear_step ? clr_q : idx_q;
	assign ram_wdata = cmd.clear_step ? '0 : {ing_n, egr_n, rcv_n, snt_n};

	sbca_ram #(.WIDTH(4 * CW), .DEPTH(ENTRIES)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (idx),
		.rdata (ram_rdata)
	);

	// RED: mark when rnd < floor(P*(e-kmin)/D), i.e. (rnd+1)*D <= P*(e-kmin).
	assign e_ext = TW'(egr);

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			gtmax_s1 <= e_ext > kmax_q;
			gtmin_s1 <= e_ext > kmin_q;
			qnz_s1   <= qnz_q;
			lhs_s1   <= LW'(17'(rnd_q) + 17'd1) * LW'(kmax_q - kmin_q);
			rhs_s1   <= PW'(prob_q) * PW'(e_ext - kmin_q);
			sent_s1  <= in_range_q ? snt_n : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= (cmd.exec && !sts.is_ecn) || cmd.ecn_fin;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			admit_ok          <= in_range_q && kind_q == sbca_pkg::REQ_CHECK
				&& free_share >= CW'(size_q);
			ecn_mark          <= 1'b0;
			credit_limit      <= (in_range_q && kind_q == sbca_pkg::REQ_CREDIT)
				? rcv + free_share : '0;
			sent_bytes_total  <= in_range_q ? snt_n : '0;
			used_buffer_total <= used_n;
		end else if (cmd.ecn_fin) begin
			ecn_mark          <= qnz_s1 && (gtmax_s1 || (gtmin_s1 && LW'(lhs_s1) <= LW'(rhs_s1)));
			sent_bytes_total  <= sent_s1;
		end
	end

	assign sts.clear_done = (clr_q == AW'(ENTRIES - 1));
	assign sts.div_busy   = div_busy_q;
	assign sts.is_ecn     = in_range_q && kind_q == sbca_pkg::REQ_ECN;

endmodule

>>> sv/sbca_checker.sv
module sbca_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input logic admit_ok,
	input logic ecn_mark
);

	a_done_follows_accept: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(start && !busy, 2) || $past(start && !busy, 3)))
		else $error("result without a recent request");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("not busy after accepting a request");

	a_single_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	a_exclusive_flags: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(admit_ok && ecn_mark))
		else $error("admit and mark both set");

endmodule

bind switch_buffer_credit_ecn_accounting_unit sbca_checker u_sbca_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.start    (start),
	.busy     (busy),
	.done     (done),
	.admit_ok (admit_ok),
	.ecn_mark (ecn_mark)
);
